// ===== sv/hcal_pkg.sv =====
// Shared types and constants for the Hermite curve arc length evaluator.
`default_nettype none
package hcal_pkg;
    localparam int FRAC_BITS = 16;
    localparam int SUB_W     = 11;
    localparam int LEN_W     = 31;
    localparam int REG_CNT   = 8;

    localparam logic [SUB_W-1:0] MAX_SUB  = SUB_W'(1024);
    localparam logic [LEN_W-1:0] LEN_MAX  = '1;
    localparam logic [16:0]      T_ONE    = 17'(1 << FRAC_BITS);

    localparam logic [1:0] KIND_POINT  = 2'd0;
    localparam logic [1:0] KIND_LENGTH = 2'd1;
    localparam logic [1:0] KIND_SEEK   = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_DIV, S_TINIT, S_STEP,
        S_EV_SQ, S_EV_CU, S_EV_H, S_EV_MUL, S_EV_ACC, S_EV_SAT,
        S_CH_DX, S_CH_SQX, S_CH_SQY, S_CH_SUM, S_SQRT, S_CH_LEN, S_CH_ADD,
        S_IP_MX, S_IP_DX, S_IP_MY, S_IP_DY, S_IP_FIN, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        DIV_STEP, DIV_X, DIV_Y
    } div_phase_t;
endpackage
`default_nettype wire

// ===== sv/hermite_curve_arc_length_eval.sv =====
// Top level of the Hermite curve arc length evaluator.
//
// Usage: write the eight curve registers (start point, start velocity, end
// point, end velocity, signed Q16.16) through the cfg channel while idle;
// cfg_ready is always high. Each request on the in channel carries kind,
// amount and subdivisions. One result per request leaves on the out channel.
// Kind 0 evaluates the curve at a clamped parameter.
// Kind 1 sums N chord lengths; kind 2 walks the same chords and
// interpolates inside the chord that holds the distance. The walk runs one
// 64-step divide up front; each chord then uses the one-bit-per-cycle square
// root (32 steps) and the shared 33x33 multiplier that serves the basis, the
// eight weight products, the squares and the interpolation products. Hitting
// a chord adds two 64-step divides for the interpolation.
// One request is worked on at a time; in_ready is high only while idle.
// A finished result sits in the output register until taken; the next
// request is accepted meanwhile, and its result waits in the sequencer if
// the receiver still stalls.
// Reset clears the curve registers to zero, drops out_valid and returns the
// sequencer to idle.
`default_nettype none
module hermite_curve_arc_length_eval (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  kind,
    input  wire logic signed [31:0] amount,
    input  wire logic [hcal_pkg::SUB_W-1:0] subdivisions,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic [hcal_pkg::LEN_W-1:0] curve_length,
    output logic             overflow
);
    import hcal_pkg::*;

    // control
    state_t state_reg, state_next;
    div_phase_t phase_reg, phase_next;
    logic out_valid_reg, out_valid_next;
    logic signed [31:0] cfg_reg [REG_CNT];

    // request
    logic [1:0] kind_reg, kind_next;
    logic signed [31:0] amount_reg, amount_next;
    logic [SUB_W-1:0] n_reg, n_next, i_reg, i_next;

    // parameter stepping
    logic [16:0] t_reg, t_next, q0_reg, q0_next, t2_reg, t2_next;
    logic [SUB_W:0] trem_reg, trem_next;
    logic [SUB_W-1:0] r0_reg, r0_next;

    // evaluation
    logic signed [19:0] h_reg [4];
    logic signed [19:0] h_next [4];
    logic [2:0] k_reg, k_next;
    logic signed [65:0] prod_reg;
    logic signed [32:0] mul_a, mul_b;
    logic signed [55:0] accx_reg, accx_next, accy_reg, accy_next;
    logic signed [31:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [31:0] prx_reg, prx_next, pry_reg, pry_next;

    // chord
    logic signed [32:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [32:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [63:0] sq_v_reg, sq_v_next, sq_res_reg, sq_res_next, sq_bit_reg, sq_bit_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] clen_reg, clen_next, len_reg, len_next;
    logic [31:0] part_reg, part_next;
    logic [LEN_W-1:0] span_reg, span_next;

    // divider
    logic [63:0] div_num_reg, div_num_next;
    logic [31:0] div_rem_reg, div_rem_next;
    logic [LEN_W-1:0] div_den_reg, div_den_next;
    logic div_neg_reg, div_neg_next;

    // result
    logic ovf_reg, ovf_next;
    logic signed [31:0] resx_reg, resx_next, resy_reg, resy_next;
    logic [LEN_W-1:0] reslen_reg, reslen_next;
    logic signed [31:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [LEN_W-1:0] olen_reg, olen_next;
    logic oovf_reg, oovf_next;

    // helpers
    logic signed [19:0] t_s, t2_s, t3_s;
    logic [32:0] satx, saty;
    logic signed [32:0] dx_w, dy_w;
    logic [32:0] ax_w, ay_w;
    logic [63:0] sq_try;
    logic [31:0] div_sh;
    logic div_ge;
    logic [31:0] len_sum;
    logic [LEN_W-1:0] len_new;
    logic len_sat;
    logic signed [33:0] q_s;
    logic [63:0] prod_mag;
    logic [SUB_W:0] trem_sum;
    logic [1:0] kk;

    // saturate an arithmetic-shifted sum to 32 bits; MSB flags saturation
    function automatic logic [32:0] sat32(input logic signed [39:0] v);
        logic [32:0] r;
        if (v > 40'sd2147483647)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -40'sd2147483648)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign point_x      = ox_reg;
    assign point_y      = oy_reg;
    assign curve_length = olen_reg;
    assign overflow     = oovf_reg;

    assign t_s  = {3'b000, t_reg};
    assign t2_s = {3'b000, t2_reg};
    assign t3_s = {3'b000, prod_reg[32:16]};
    assign satx = sat32(accx_reg[55:16]);
    assign saty = sat32(accy_reg[55:16]);
    assign dx_w = {cx_reg[31], cx_reg} - {prx_reg[31], prx_reg};
    assign dy_w = {cy_reg[31], cy_reg} - {pry_reg[31], pry_reg};
    assign ax_w = dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
    assign ay_w = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
    assign sq_try = sq_res_reg + sq_bit_reg;
    assign div_sh = {div_rem_reg[30:0], div_num_reg[63]};
    assign div_ge = div_sh >= {1'b0, div_den_reg};
    assign len_sum = {1'b0, len_reg} + {1'b0, clen_reg};
    assign len_sat = len_sum[31];
    assign len_new = len_sat ? LEN_MAX : len_sum[LEN_W-1:0];
    assign q_s = div_neg_reg ? -$signed({1'b0, div_num_reg[32:0]})
                             : $signed({1'b0, div_num_reg[32:0]});
    assign prod_mag = prod_reg[65] ? 64'(-prod_reg) : 64'(prod_reg);
    assign trem_sum = trem_reg + {1'b0, r0_reg};
    assign kk = k_reg[1:0];

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_EV_SQ:
            begin
                mul_a = {16'b0, t_reg};
                mul_b = {16'b0, t_reg};
            end
            S_EV_CU:
            begin
                mul_a = {16'b0, prod_reg[32:16]};
                mul_b = {16'b0, t_reg};
            end
            S_EV_MUL:
            begin
                mul_a = {cfg_reg[{kk, k_reg[2]}][31], cfg_reg[{kk, k_reg[2]}]};
                mul_b = 33'(h_reg[kk]);
            end
            S_CH_SQX:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            S_CH_SQY:
            begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            S_IP_MX:
            begin
                mul_a = dx_reg;
                mul_b = {1'b0, part_reg};
            end
            S_IP_MY:
            begin
                mul_a = dy_reg;
                mul_b = {1'b0, part_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        out_valid_next = out_valid_reg;
        kind_next = kind_reg;
        amount_next = amount_reg;
        n_next = n_reg;
        i_next = i_reg;
        t_next = t_reg;
        q0_next = q0_reg;
        t2_next = t2_reg;
        trem_next = trem_reg;
        r0_next = r0_reg;
        h_next = h_reg;
        k_next = k_reg;
        accx_next = accx_reg;
        accy_next = accy_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        prx_next = prx_reg;
        pry_next = pry_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        ax_next = ax_reg;
        ay_next = ay_reg;
        sq_v_next = sq_v_reg;
        sq_res_next = sq_res_reg;
        sq_bit_next = sq_bit_reg;
        cnt_next = cnt_reg;
        clen_next = clen_reg;
        len_next = len_reg;
        part_next = part_reg;
        span_next = span_reg;
        div_num_next = div_num_reg;
        div_rem_next = div_rem_reg;
        div_den_next = div_den_reg;
        div_neg_next = div_neg_reg;
        ovf_next = ovf_reg;
        resx_next = resx_reg;
        resy_next = resy_reg;
        reslen_next = reslen_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        olen_next = olen_reg;
        oovf_next = oovf_reg;

        // drop the result once taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = kind;
                    amount_next = amount;
                    if (subdivisions == '0)
                        n_next = SUB_W'(1);
                    else if (subdivisions > MAX_SUB)
                        n_next = MAX_SUB;
                    else
                        n_next = subdivisions;
                    ovf_next = 1'b0;
                    resx_next = '0;
                    resy_next = '0;
                    reslen_next = '0;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                case (kind_reg)
                    KIND_POINT:
                    begin
                        if (amount_reg[31])
                            t_next = '0;
                        else if (amount_reg > $signed({15'b0, T_ONE}))
                            t_next = T_ONE;
                        else
                            t_next = amount_reg[16:0];
                        state_next = S_EV_SQ;
                    end
                    KIND_LENGTH, KIND_SEEK:
                    begin
                        if (kind_reg == KIND_SEEK && amount_reg <= 32'sd0)
                        begin
                            resx_next = cfg_reg[0];
                            resy_next = cfg_reg[1];
                            state_next = S_DONE;
                        end
                        else
                        begin
                            // step size one / N as quotient and remainder
                            div_num_next = 64'(T_ONE);
                            div_rem_next = '0;
                            div_den_next = LEN_W'(n_reg);
                            div_neg_next = 1'b0;
                            cnt_next = '0;
                            phase_next = DIV_STEP;
                            state_next = S_DIV;
                        end
                    end
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_DIV:
            begin
                div_rem_next = div_ge ? div_sh - {1'b0, div_den_reg} : div_sh;
                div_num_next = {div_num_reg[62:0], div_ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    case (phase_reg)
                        DIV_STEP: state_next = S_TINIT;
                        DIV_X:    state_next = S_IP_MY;
                        default:  state_next = S_IP_FIN;
                    endcase
                end
            end
            S_TINIT:
            begin
                q0_next = div_num_reg[16:0];
                r0_next = div_rem_reg[SUB_W-1:0];
                t_next = '0;
                trem_next = '0;
                i_next = '0;
                len_next = '0;
                prx_next = cfg_reg[0];
                pry_next = cfg_reg[1];
                state_next = S_STEP;
            end
            S_STEP:
            begin
                // advance t by one / N, carrying the remainder
                i_next = i_reg + SUB_W'(1);
                if (trem_sum >= {1'b0, n_reg})
                begin
                    trem_next = trem_sum - {1'b0, n_reg};
                    t_next = t_reg + q0_reg + 17'd1;
                end
                else
                begin
                    trem_next = trem_sum;
                    t_next = t_reg + q0_reg;
                end
                state_next = S_EV_SQ;
            end
            S_EV_SQ:
                state_next = S_EV_CU;
            S_EV_CU:
            begin
                t2_next = prod_reg[32:16];
                state_next = S_EV_H;
            end
            S_EV_H:
            begin
                h_next[0] = (t3_s <<< 1) - (t2_s + (t2_s <<< 1)) + $signed({3'b0, T_ONE});
                h_next[1] = t3_s - (t2_s <<< 1) + t_s;
                h_next[2] = (t2_s + (t2_s <<< 1)) - (t3_s <<< 1);
                h_next[3] = t3_s - t2_s;
                accx_next = '0;
                accy_next = '0;
                k_next = '0;
                state_next = S_EV_MUL;
            end
            S_EV_MUL:
                state_next = S_EV_ACC;
            S_EV_ACC:
            begin
                if (k_reg[2])
                    accy_next = accy_reg + prod_reg[55:0];
                else
                    accx_next = accx_reg + prod_reg[55:0];
                k_next = k_reg + 3'd1;
                state_next = (k_reg == 3'd7) ? S_EV_SAT : S_EV_MUL;
            end
            S_EV_SAT:
            begin
                cx_next = satx[31:0];
                cy_next = saty[31:0];
                ovf_next = ovf_reg | satx[32] | saty[32];
                if (kind_reg == KIND_POINT)
                begin
                    resx_next = satx[31:0];
                    resy_next = saty[31:0];
                    state_next = S_DONE;
                end
                else
                    state_next = S_CH_DX;
            end
            S_CH_DX:
            begin
                dx_next = dx_w;
                dy_next = dy_w;
                ax_next = ax_w;
                ay_next = ay_w;
                if (ax_w > {2'b0, LEN_MAX} || ay_w > {2'b0, LEN_MAX})
                begin
                    clen_next = LEN_MAX;
                    ovf_next = 1'b1;
                    state_next = S_CH_ADD;
                end
                else
                    state_next = S_CH_SQX;
            end
            S_CH_SQX:
                state_next = S_CH_SQY;
            S_CH_SQY:
            begin
                sq_v_next = prod_reg[63:0];
                state_next = S_CH_SUM;
            end
            S_CH_SUM:
            begin
                sq_v_next = sq_v_reg + prod_reg[63:0];
                sq_res_next = '0;
                sq_bit_next = 64'h4000_0000_0000_0000;
                cnt_next = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (sq_v_reg >= sq_try)
                begin
                    sq_v_next = sq_v_reg - sq_try;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_next = sq_res_reg >> 1;
                sq_bit_next = sq_bit_reg >> 2;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                    state_next = S_CH_LEN;
            end
            S_CH_LEN:
            begin
                if (sq_res_reg > {33'b0, LEN_MAX})
                begin
                    clen_next = LEN_MAX;
                    ovf_next = 1'b1;
                end
                else
                    clen_next = sq_res_reg[LEN_W-1:0];
                state_next = S_CH_ADD;
            end
            S_CH_ADD:
            begin
                len_next = len_new;
                if (len_sat)
                    ovf_next = 1'b1;
                if (kind_reg == KIND_SEEK && amount_reg > $signed({1'b0, len_reg})
                    && amount_reg <= $signed({1'b0, len_new}))
                begin
                    part_next = 32'(amount_reg) - {1'b0, len_reg};
                    span_next = len_new - len_reg;
                    state_next = S_IP_MX;
                end
                else if (i_reg == n_reg)
                begin
                    if (kind_reg == KIND_LENGTH)
                        reslen_next = len_new;
                    else
                    begin
                        resx_next = cfg_reg[4];
                        resy_next = cfg_reg[5];
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    prx_next = cx_reg;
                    pry_next = cy_reg;
                    state_next = S_STEP;
                end
            end
            S_IP_MX:
                state_next = S_IP_DX;
            S_IP_DX:
            begin
                div_num_next = prod_mag;
                div_rem_next = '0;
                div_den_next = span_reg;
                div_neg_next = prod_reg[65];
                cnt_next = '0;
                phase_next = DIV_X;
                state_next = S_DIV;
            end
            S_IP_MY:
            begin
                resx_next = prx_reg + q_s[31:0];
                state_next = S_IP_DY;
            end
            S_IP_DY:
            begin
                div_num_next = prod_mag;
                div_rem_next = '0;
                div_den_next = span_reg;
                div_neg_next = prod_reg[65];
                cnt_next = '0;
                phase_next = DIV_Y;
                state_next = S_DIV;
            end
            S_IP_FIN:
            begin
                resy_next = pry_reg + q_s[31:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    ox_next = resx_reg;
                    oy_next = resy_reg;
                    olen_next = reslen_reg;
                    oovf_next = ovf_reg;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < REG_CNT; r++)
                cfg_reg[r] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
                cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        kind_reg <= kind_next;
        amount_reg <= amount_next;
        n_reg <= n_next;
        i_reg <= i_next;
        t_reg <= t_next;
        q0_reg <= q0_next;
        t2_reg <= t2_next;
        trem_reg <= trem_next;
        r0_reg <= r0_next;
        h_reg <= h_next;
        k_reg <= k_next;
        prod_reg <= mul_a * mul_b;
        accx_reg <= accx_next;
        accy_reg <= accy_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        prx_reg <= prx_next;
        pry_reg <= pry_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        ax_reg <= ax_next;
        ay_reg <= ay_next;
        sq_v_reg <= sq_v_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
        cnt_reg <= cnt_next;
        clen_reg <= clen_next;
        len_reg <= len_next;
        part_reg <= part_next;
        span_reg <= span_next;
        div_num_reg <= div_num_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        div_neg_reg <= div_neg_next;
        ovf_reg <= ovf_next;
        resx_reg <= resx_next;
        resy_reg <= resy_next;
        reslen_reg <= reslen_next;
        ox_reg <= ox_next;
        oy_reg <= oy_next;
        olen_reg <= olen_next;
        oovf_reg <= oovf_next;
    end
endmodule
`default_nettype wire
